>>> sv/grp_pkg.sv
// grp_pkg: shared types, constants and helpers for the gre receive parser
// no dependencies; used by grp_accum, grp_verdict and gre_receive_parser
package grp_pkg;

    // largest packet length counted, in bytes (default for the top level parameter)
    localparam int DEFAULT_MAX_PACKET_BYTES = 65535;

    // gre base header and protocol constants
    localparam int          BASE_HDR_BYTES  = 4;
    localparam logic [15:0] TEB_PROTOCOL    = 16'h6558;
    localparam logic [7:0]  INNER_ETH_BYTES = 8'd14;

    // flag halfword bit positions
    localparam int F_CSUM_BIT  = 15;
    localparam int F_ROUTE_BIT = 14;
    localparam int F_KEY_BIT   = 13;
    localparam int F_SEQ_BIT   = 12;
    localparam logic [15:0] F_VER_MASK = 16'h0007;

    // word position counter
    localparam int              INDEX_W   = 14;
    localparam logic [INDEX_W-1:0] INDEX_TOP = 14'h3FFF;

    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        CFG_EXPECTED_PROTOCOL  = 2'd0,
        CFG_PLAIN_PORT_PRESENT = 2'd1,
        CFG_WIDE_PORT_PRESENT  = 2'd2,
        CFG_MIN_INNER_BYTES    = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_SHORT_BASE   = 3'd1,
        ST_BAD_CSUM     = 3'd2,
        ST_VER_ROUTE    = 3'd3,
        ST_BAD_PROTOCOL = 3'd4,
        ST_NO_PORT      = 3'd5,
        ST_SHORT_HEADER = 3'd6
    } status_t;

    typedef struct packed {
        logic [15:0] expected_protocol;
        logic        plain_port_present;
        logic        wide_port_present;
        logic [7:0]  min_inner_bytes;
    } cfg_t;

    // captured header words and running checksum of one packet
    typedef struct packed {
        logic [15:0] flag_field;
        logic [15:0] protocol_field;
        logic [31:0] key_word;
        logic [31:0] seq_word;
        logic [15:0] ones_sum;
    } pkt_fields_t;

    typedef struct packed {
        status_t     status;
        logic [4:0]  header_bytes;
        logic [63:0] tunnel_id;
        logic        is_wide;
        logic        tunnel_key_flag;
        logic        tunnel_csum_flag;
        logic [15:0] raw_flags;
    } verdict_t;

    // ones'-complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

>>> sv/grp_if.sv
// grp_if: valid/ready channel interfaces for packet words and verdicts
// depends on nothing
interface grp_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] packet_word;
    logic [2:0]  valid_bytes;
    logic        last_word;

    modport source (output valid, packet_word, valid_bytes, last_word, input ready);
    modport sink   (input valid, packet_word, valid_bytes, last_word, output ready);
endinterface

interface grp_verdict_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [4:0]  header_bytes;
    logic [63:0] tunnel_id;
    logic        is_wide;
    logic        tunnel_key_flag;
    logic        tunnel_csum_flag;
    logic [15:0] raw_flags;

    modport source (output valid, status, header_bytes, tunnel_id, is_wide,
                    tunnel_key_flag, tunnel_csum_flag, raw_flags, input ready);
    modport sink   (input valid, status, header_bytes, tunnel_id, is_wide,
                    tunnel_key_flag, tunnel_csum_flag, raw_flags, output ready);
endinterface

>>> sv/grp_accum.sv
// grp_accum: per-packet capture of flags, protocol, key, sequence, byte count, checksum
// depends on grp_pkg
module grp_accum #(
    parameter int MAX_PACKET_BYTES = grp_pkg::DEFAULT_MAX_PACKET_BYTES,
    localparam int BYTE_W = $clog2(MAX_PACKET_BYTES + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [31:0]           packet_word,
    input  logic [2:0]            valid_bytes,
    input  logic                  last_word,
    output grp_pkg::pkt_fields_t  fields_next,
    output logic [BYTE_W-1:0]     byte_count_next
);

    localparam logic [BYTE_W:0] MAX_BYTES = (BYTE_W + 1)'(MAX_PACKET_BYTES);

    grp_pkg::pkt_fields_t          fields_reg;
    logic [BYTE_W-1:0]             byte_count_reg;
    logic [grp_pkg::INDEX_W-1:0]   word_index_reg;
    logic [grp_pkg::INDEX_W-1:0]   word_index_next;

    logic [2:0]         vb;
    logic [31:0]        mask;
    logic [31:0]        w;
    logic               c;
    logic               k;
    logic [BYTE_W:0]    bc_sum;
    logic [grp_pkg::INDEX_W-1:0] key_pos;
    logic [grp_pkg::INDEX_W-1:0] seq_pos;

    always_comb
    begin
        vb = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
        case (vb)
            3'd1:    mask = 32'hFF00_0000;
            3'd2:    mask = 32'hFFFF_0000;
            3'd3:    mask = 32'hFFFF_FF00;
            3'd4:    mask = 32'hFFFF_FFFF;
            default: mask = 32'h0000_0000;
        endcase
        w = packet_word & mask;

        c       = fields_reg.flag_field[grp_pkg::F_CSUM_BIT];
        k       = fields_reg.flag_field[grp_pkg::F_KEY_BIT];
        key_pos = grp_pkg::INDEX_W'(1) + {{(grp_pkg::INDEX_W-1){1'b0}}, c};
        seq_pos = grp_pkg::INDEX_W'(2) + {{(grp_pkg::INDEX_W-1){1'b0}}, c};

        fields_next = fields_reg;
        if (word_index_reg == '0)
        begin
            fields_next.flag_field     = w[31:16];
            fields_next.protocol_field = w[15:0];
        end
        else if (k && word_index_reg == key_pos)
        begin
            fields_next.key_word = w;
        end
        else if (k && fields_reg.flag_field[grp_pkg::F_SEQ_BIT] && word_index_reg == seq_pos)
        begin
            fields_next.seq_word = w;
        end
        fields_next.ones_sum = grp_pkg::ones_add(
            grp_pkg::ones_add(fields_reg.ones_sum, w[31:16]), w[15:0]);

        // byte count saturates at the configured packet limit
        bc_sum = {1'b0, byte_count_reg} + (BYTE_W + 1)'(vb);
        byte_count_next = (bc_sum > MAX_BYTES) ? MAX_BYTES[BYTE_W-1:0] : bc_sum[BYTE_W-1:0];

        word_index_next = (word_index_reg < grp_pkg::INDEX_TOP) ?
                          word_index_reg + grp_pkg::INDEX_W'(1) : word_index_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fields_reg     <= '0;
            byte_count_reg <= '0;
            word_index_reg <= '0;
        end
        else if (accept)
        begin
            if (last_word)
            begin
                fields_reg     <= '0;
                byte_count_reg <= '0;
                word_index_reg <= '0;
            end
            else
            begin
                fields_reg     <= fields_next;
                byte_count_reg <= byte_count_next;
                word_index_reg <= word_index_next;
            end
        end
    end

endmodule

>>> sv/grp_verdict.sv
// grp_verdict: check chain and result fields for a finished packet
// depends on grp_pkg
module grp_verdict #(
    parameter int MAX_PACKET_BYTES = grp_pkg::DEFAULT_MAX_PACKET_BYTES,
    localparam int BYTE_W = $clog2(MAX_PACKET_BYTES + 1)
) (
    input  grp_pkg::cfg_t         cfg,
    input  grp_pkg::pkt_fields_t  fields,
    input  logic [BYTE_W-1:0]     byte_count,
    output grp_pkg::verdict_t     verdict
);

    localparam int CMP_W = ((BYTE_W > 9) ? BYTE_W : 9) + 1;

    logic             c;
    logic             k;
    logic             s;
    logic             wide;
    logic [4:0]       hdr;
    logic [CMP_W-1:0] bc;
    logic [CMP_W-1:0] base_need;
    logic [CMP_W-1:0] full_need;
    logic             port_ok;

    always_comb
    begin
        c    = fields.flag_field[grp_pkg::F_CSUM_BIT];
        k    = fields.flag_field[grp_pkg::F_KEY_BIT];
        s    = fields.flag_field[grp_pkg::F_SEQ_BIT];
        wide = k & s;
        hdr  = 5'(grp_pkg::BASE_HDR_BYTES) * (5'd1 + 5'(c) + 5'(k) + 5'(s));

        bc        = CMP_W'(byte_count);
        base_need = CMP_W'(grp_pkg::BASE_HDR_BYTES) + CMP_W'(cfg.min_inner_bytes);
        full_need = CMP_W'(hdr) + CMP_W'(cfg.min_inner_bytes);
        port_ok   = wide ? cfg.wide_port_present : cfg.plain_port_present;

        if (bc < base_need)
            verdict.status = grp_pkg::ST_SHORT_BASE;
        else if (c && fields.ones_sum != 16'hFFFF)
            verdict.status = grp_pkg::ST_BAD_CSUM;
        else if ((fields.flag_field & (grp_pkg::F_VER_MASK |
                  (16'd1 << grp_pkg::F_ROUTE_BIT))) != '0)
            verdict.status = grp_pkg::ST_VER_ROUTE;
        else if (fields.protocol_field != cfg.expected_protocol)
            verdict.status = grp_pkg::ST_BAD_PROTOCOL;
        else if (!port_ok)
            verdict.status = grp_pkg::ST_NO_PORT;
        else if (bc < full_need)
            verdict.status = grp_pkg::ST_SHORT_HEADER;
        else
            verdict.status = grp_pkg::ST_OK;

        verdict.header_bytes     = hdr;
        verdict.tunnel_id        = k ? {fields.key_word, (wide ? fields.seq_word : 32'd0)}
                                     : 64'd0;
        verdict.is_wide          = wide;
        verdict.tunnel_key_flag  = k;
        verdict.tunnel_csum_flag = c;
        verdict.raw_flags        = fields.flag_field;
    end

endmodule

>>> sv/gre_receive_parser.sv
// gre_receive_parser: top level of the gre header parser (rfc 2784 / 2890 layout)
// depends on grp_pkg, grp_if, grp_accum, grp_verdict
// usage
//   pkt_in carries a gre packet as big-endian 32-bit words, starting at the
//   gre base header; valid_bytes tells how many top bytes count, last_word
//   marks the final word. every word is one transfer.
//   verdict_out carries one result per packet, made from its last word:
//   status, header length, 64-bit tunnel id and flags.
//   cfg_write/cfg_index/cfg_data write the four settings registers
//   (expected protocol, plain port, wide port, minimum inner bytes); write
//   them only while no packet is in flight.
// latency and throughput
//   one word per cycle unless stalled; the verdict is valid the cycle after the last
//   word's transfer, capture, checksum and checks all ahead of the result register
// reset
//   rst_n clears the packet state, drops any held verdict and loads the
//   settings with their defaults (0x6558, both ports present, 14 bytes).
// stall
//   while a verdict waits and verdict_out.ready is low, pkt_in.ready drops;
//   when the held verdict leaves in the same cycle, a new word is still taken.
module gre_receive_parser #(
    parameter int MAX_PACKET_BYTES = grp_pkg::DEFAULT_MAX_PACKET_BYTES,
    localparam int BYTE_W = $clog2(MAX_PACKET_BYTES + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    grp_word_if.sink                       pkt_in,
    grp_verdict_if.source                  verdict_out,
    input  logic                           cfg_write,
    input  logic [1:0]                     cfg_index,
    input  logic [grp_pkg::CFG_DATA_W-1:0] cfg_data
);

    // settings registers
    grp_pkg::cfg_t cfg_reg;

    // result register
    logic              out_valid_reg;
    grp_pkg::verdict_t out_reg;

    grp_pkg::pkt_fields_t fields_next;
    logic [BYTE_W-1:0]    byte_count_next;
    grp_pkg::verdict_t    verdict;
    logic                 accept;

    // take a word whenever the result register is empty or draining
    assign pkt_in.ready = !out_valid_reg || verdict_out.ready;
    assign accept       = pkt_in.valid && pkt_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_protocol  <= grp_pkg::TEB_PROTOCOL;
            cfg_reg.plain_port_present <= 1'b1;
            cfg_reg.wide_port_present  <= 1'b1;
            cfg_reg.min_inner_bytes    <= grp_pkg::INNER_ETH_BYTES;
        end
        else if (cfg_write)
        begin
            case (grp_pkg::cfg_index_t'(cfg_index))
                grp_pkg::CFG_EXPECTED_PROTOCOL:  cfg_reg.expected_protocol  <= cfg_data[15:0];
                grp_pkg::CFG_PLAIN_PORT_PRESENT: cfg_reg.plain_port_present <= cfg_data[0];
                grp_pkg::CFG_WIDE_PORT_PRESENT:  cfg_reg.wide_port_present  <= cfg_data[0];
                grp_pkg::CFG_MIN_INNER_BYTES:    cfg_reg.min_inner_bytes    <= cfg_data[7:0];
                default:                         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // capture and running checksum
    grp_accum #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_accum (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .packet_word     (pkt_in.packet_word),
        .valid_bytes     (pkt_in.valid_bytes),
        .last_word       (pkt_in.last_word),
        .fields_next     (fields_next),
        .byte_count_next (byte_count_next)
    );

    // checks on the state as it stands after the current word
    grp_verdict #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_verdict (
        .cfg        (cfg_reg),
        .fields     (fields_next),
        .byte_count (byte_count_next),
        .verdict    (verdict)
    );

    // result register: loads on the last word's transfer, empties on output transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && pkt_in.last_word)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (verdict_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && pkt_in.last_word)
        begin
            out_reg <= verdict;
        end
    end

    assign verdict_out.valid            = out_valid_reg;
    assign verdict_out.status           = out_reg.status;
    assign verdict_out.header_bytes     = out_reg.header_bytes;
    assign verdict_out.tunnel_id        = out_reg.tunnel_id;
    assign verdict_out.is_wide          = out_reg.is_wide;
    assign verdict_out.tunnel_key_flag  = out_reg.tunnel_key_flag;
    assign verdict_out.tunnel_csum_flag = out_reg.tunnel_csum_flag;
    assign verdict_out.raw_flags        = out_reg.raw_flags;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for gre_receive_parser, word stream in, one verdict per packet out
// depends on grp_pkg, grp_if and the parser rtl; predicts every verdict from its own parse model
module tb_top;

    localparam int MAX_BYTES      = grp_pkg::DEFAULT_MAX_PACKET_BYTES;
    localparam int STALL_MAX      = 10;     // longest idle draw on either side
    localparam int WATCHDOG_LIMIT = 1000;   // cycles with no transfer at all
    localparam int RANDOM_WORDS   = 1800;
    localparam int RANDOM_PHASES  = 6;
    localparam int LONG_WORDS     = 64;     // one longer checksummed packet at the end

    // one packet word as the sender sees it
    typedef struct {
        logic [31:0] word;
        logic [2:0]  vbytes;
        logic        last;
        int unsigned gap;      // idle cycles before this word is offered
        bit          drain;    // hold this word until every verdict has come back
    } word_xfer_t;

    // per-packet parse state, cleared after each last word
    typedef struct {
        logic [grp_pkg::INDEX_W-1:0] word_pos;
        logic [15:0]                 byte_total;
        logic [15:0]                 flags;
        logic [15:0]                 protocol;
        logic [31:0]                 key;
        logic [31:0]                 seq;
        logic [15:0]                 csum;
    } parse_state_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_write;
    logic [1:0]                     cfg_index;
    logic [grp_pkg::CFG_DATA_W-1:0] cfg_data;

    grp_word_if    pkt_if ();
    grp_verdict_if verdict_if ();

    gre_receive_parser #(
        .MAX_PACKET_BYTES(MAX_BYTES)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt_in     (pkt_if),
        .verdict_out(verdict_if),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // parse model state and its copy of the settings registers
    parse_state_t  pstate = '{default: '0};
    grp_pkg::cfg_t settings;

    word_xfer_t          staged[$];            // packet under construction
    word_xfer_t          word_backlog[$];      // words waiting for the driver
    grp_pkg::verdict_t   pending_verdicts[$];  // predicted verdicts, oldest first
    word_xfer_t          on_wire;              // word currently offered on pkt_if
    grp_pkg::verdict_t   predicted;
    int unsigned         words_queued = 0;
    int unsigned         words_taken = 0;
    int unsigned         gap_count;
    int unsigned         stall_left;
    int unsigned         quiet_cycles;
    int                  fault_count = 0;
    bit                  rx_calm = 1'b0;       // receiver never stalls in this phase

    // ------------------------------------------------------------------
    // parse model
    // ------------------------------------------------------------------

    // 16-bit ones'-complement add, carry out wraps back into bit 0
    function automatic logic [15:0] csum_add(input logic [15:0] acc, input logic [15:0] half);
        logic [16:0] wide_sum;
        wide_sum = {1'b0, acc} + {1'b0, half};
        return wide_sum[15:0] + {15'd0, wide_sum[16]};
    endfunction

    // bytes of the word that count; 0 keeps nothing, anything above 4 keeps all
    function automatic logic [31:0] kept_bytes(input word_xfer_t xfer);
        logic [2:0] nbytes;
        nbytes = (xfer.vbytes > 3'd4) ? 3'd4 : xfer.vbytes;
        if (nbytes == 3'd0)
            return 32'd0;
        return xfer.word & (32'hFFFF_FFFF << (32 - 8 * int'(nbytes)));
    endfunction

    // absorb one accepted word; returns 1 with the verdict when it closes a packet
    function automatic bit parse_word(input word_xfer_t xfer, output grp_pkg::verdict_t result);
        logic [2:0]       nbytes;
        logic [31:0]      data;
        logic [16:0]      total;
        logic             c;
        logic             k;
        logic             s;
        logic             wide;
        logic [4:0]       hdr;
        logic [8:0]       base_need;
        logic [8:0]       full_need;
        grp_pkg::status_t st;

        nbytes = (xfer.vbytes > 3'd4) ? 3'd4 : xfer.vbytes;
        data   = kept_bytes(xfer);

        // key and sequence slots move down by one word when a checksum word is present
        c = pstate.flags[grp_pkg::F_CSUM_BIT];
        k = pstate.flags[grp_pkg::F_KEY_BIT];
        if (pstate.word_pos == '0)
        begin
            pstate.flags    = data[31:16];
            pstate.protocol = data[15:0];
        end
        else if (k && pstate.word_pos == grp_pkg::INDEX_W'(1) + grp_pkg::INDEX_W'(c))
        begin
            pstate.key = data;
        end
        else if (k && pstate.flags[grp_pkg::F_SEQ_BIT] &&
                 pstate.word_pos == grp_pkg::INDEX_W'(2) + grp_pkg::INDEX_W'(c))
        begin
            pstate.seq = data;
        end

        pstate.csum = csum_add(csum_add(pstate.csum, data[31:16]), data[15:0]);
        total = {1'b0, pstate.byte_total} + 17'(nbytes);
        pstate.byte_total = (total > 17'(MAX_BYTES)) ? 16'(MAX_BYTES) : total[15:0];
        if (pstate.word_pos != grp_pkg::INDEX_TOP)
            pstate.word_pos++;

        if (!xfer.last)
            return 1'b0;

        c    = pstate.flags[grp_pkg::F_CSUM_BIT];
        k    = pstate.flags[grp_pkg::F_KEY_BIT];
        s    = pstate.flags[grp_pkg::F_SEQ_BIT];
        wide = k & s;
        hdr  = 5'(grp_pkg::BASE_HDR_BYTES * (1 + int'(c) + int'(k) + int'(s)));
        base_need = 9'(grp_pkg::BASE_HDR_BYTES) + 9'(settings.min_inner_bytes);
        full_need = 9'(hdr) + 9'(settings.min_inner_bytes);

        // first failing check wins
        if (pstate.byte_total < 16'(base_need))
            st = grp_pkg::ST_SHORT_BASE;
        else if (c && pstate.csum != 16'hFFFF)
            st = grp_pkg::ST_BAD_CSUM;
        else if ((pstate.flags & grp_pkg::F_VER_MASK) != 16'd0 ||
                 pstate.flags[grp_pkg::F_ROUTE_BIT])
            st = grp_pkg::ST_VER_ROUTE;
        else if (pstate.protocol != settings.expected_protocol)
            st = grp_pkg::ST_BAD_PROTOCOL;
        else if (wide ? !settings.wide_port_present : !settings.plain_port_present)
            st = grp_pkg::ST_NO_PORT;
        else if (pstate.byte_total < 16'(full_need))
            st = grp_pkg::ST_SHORT_HEADER;
        else
            st = grp_pkg::ST_OK;

        // fields come from whatever was captured, whatever the status
        result.status           = st;
        result.header_bytes     = hdr;
        result.tunnel_id        = k ? {pstate.key, (wide ? pstate.seq : 32'd0)} : 64'd0;
        result.is_wide          = wide;
        result.tunnel_key_flag  = k;
        result.tunnel_csum_flag = c;
        result.raw_flags        = pstate.flags;

        pstate = '{default: '0};
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // packet construction
    // ------------------------------------------------------------------

    // flag the final staged word as the end of the packet
    task automatic close_packet();
        word_xfer_t xfer;
        xfer = staged[staged.size() - 1];
        xfer.last = 1'b1;
        staged[staged.size() - 1] = xfer;
    endtask

    // base header, optional checksum/key/sequence words, then random payload
    task automatic build_packet(input logic [15:0] flags, input logic [15:0] proto,
                                input logic [31:0] key, input logic [31:0] seq,
                                input int payload_bytes, input bit good_csum);
        word_xfer_t  xfer;
        logic [31:0] data;
        logic [15:0] sum;
        int          csum_slot;

        staged.delete();
        csum_slot = -1;
        xfer = '{word: {flags, proto}, vbytes: 3'd4, last: 1'b0, gap: 0, drain: 1'b0};
        staged.push_back(xfer);
        if (flags[grp_pkg::F_CSUM_BIT])
        begin
            // checksum field starts at zero, reserved half is random
            csum_slot = staged.size();
            xfer.word = {16'h0000, 16'($urandom)};
            staged.push_back(xfer);
        end
        if (flags[grp_pkg::F_KEY_BIT])
        begin
            xfer.word = key;
            staged.push_back(xfer);
        end
        if (flags[grp_pkg::F_SEQ_BIT])
        begin
            xfer.word = seq;
            staged.push_back(xfer);
        end
        while (payload_bytes > 0)
        begin
            xfer.word   = $urandom;
            xfer.vbytes = (payload_bytes >= 4) ? 3'd4 : 3'(payload_bytes);
            staged.push_back(xfer);
            payload_bytes -= 4;
        end
        close_packet();

        if (csum_slot >= 0)
        begin
            sum = 16'd0;
            foreach (staged[i])
            begin
                data = kept_bytes(staged[i]);
                sum  = csum_add(csum_add(sum, data[31:16]), data[15:0]);
            end
            xfer = staged[csum_slot];
            xfer.word[31:16] = good_csum ? ~sum : 16'($urandom);
            staged[csum_slot] = xfer;
        end
    endtask

    // junk words with any valid_bytes code
    task automatic build_noise(input int count);
        word_xfer_t xfer;
        staged.delete();
        repeat (count)
        begin
            xfer = '{word: $urandom, vbytes: 3'($urandom_range(0, 7)), last: 1'b0,
                     gap: 0, drain: 1'b0};
            staged.push_back(xfer);
        end
        close_packet();
    endtask

    // move the staged packet to the driver, drawing the sender's idle per word
    task automatic commit_packet(input bit drain);
        word_xfer_t xfer;
        bit         calm;
        calm = ($urandom_range(0, 3) == 0);
        foreach (staged[i])
        begin
            xfer       = staged[i];
            xfer.gap   = calm ? 0 : $urandom_range(0, STALL_MAX);
            xfer.drain = drain && (i == 0);
            word_backlog.push_back(xfer);
        end
        words_queued += staged.size();
    endtask

    // mostly well-formed packets for the current settings, the rest broken or noise
    task automatic random_packet();
        logic [15:0] flags;
        logic [15:0] proto;
        word_xfer_t  xfer;
        int          kind;
        int          payload;
        int          pick;

        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            build_noise($urandom_range(1, 6));
            return;
        end

        flags = {1'($urandom), 1'b0, 1'($urandom), 1'($urandom), 12'h000};
        if ($urandom_range(0, 3) == 0)
            flags[11:3] = 9'($urandom);
        proto = settings.expected_protocol;
        if (kind >= 70)
        begin
            // header halves taken at random: routing, version, any protocol
            flags = 16'($urandom);
            if ($urandom_range(0, 1) == 1)
                proto = 16'($urandom);
        end

        payload = settings.min_inner_bytes + $urandom_range(0, 20);
        if ($urandom_range(0, 4) == 0)
            payload = $urandom_range(0, settings.min_inner_bytes + 3);
        build_packet(flags, proto, $urandom, $urandom, payload, $urandom_range(0, 9) != 0);

        if (kind >= 85 && staged.size() > 1)
        begin
            // cut short somewhere inside
            repeat ($urandom_range(1, staged.size() - 1))
                void'(staged.pop_back());
            close_packet();
        end
        else if (kind >= 60 && kind < 70)
        begin
            // odd valid_bytes code on one word, possibly mid packet
            pick = $urandom_range(0, staged.size() - 1);
            xfer = staged[pick];
            xfer.vbytes = 3'($urandom_range(0, 7));
            staged[pick] = xfer;
        end
    endtask

    // ------------------------------------------------------------------
    // settings writes
    // ------------------------------------------------------------------

    // one register per clock, model copy follows with the same truncation
    task automatic write_reg(input grp_pkg::cfg_index_t idx,
                             input logic [grp_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            grp_pkg::CFG_EXPECTED_PROTOCOL:  settings.expected_protocol  = data;
            grp_pkg::CFG_PLAIN_PORT_PRESENT: settings.plain_port_present = data[0];
            grp_pkg::CFG_WIDE_PORT_PRESENT:  settings.wide_port_present  = data[0];
            grp_pkg::CFG_MIN_INNER_BYTES:    settings.min_inner_bytes    = data[7:0];
            default: ;
        endcase
    endtask

    // all four registers; unused upper data bits carry junk
    task automatic apply_settings(input logic [15:0] proto, input bit plain, input bit wide,
                                  input logic [7:0] inner);
        write_reg(grp_pkg::CFG_EXPECTED_PROTOCOL, proto);
        write_reg(grp_pkg::CFG_PLAIN_PORT_PRESENT, {15'($urandom), plain});
        write_reg(grp_pkg::CFG_WIDE_PORT_PRESENT, {15'($urandom), wide});
        write_reg(grp_pkg::CFG_MIN_INNER_BYTES, {8'($urandom), inner});
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // every queued word taken and every predicted verdict seen, plus output latency
    task automatic wait_idle();
        do
            @(posedge clk);
        while (words_taken != words_queued || pending_verdicts.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fault_count++;
        end
    endtask

    task automatic check_verdict(input grp_pkg::verdict_t want);
        check_field("status", want.status, verdict_if.status);
        check_field("header_bytes", want.header_bytes, verdict_if.header_bytes);
        check_field("tunnel_id", want.tunnel_id, verdict_if.tunnel_id);
        check_field("is_wide", want.is_wide, verdict_if.is_wide);
        check_field("tunnel_key_flag", want.tunnel_key_flag, verdict_if.tunnel_key_flag);
        check_field("tunnel_csum_flag", want.tunnel_csum_flag, verdict_if.tunnel_csum_flag);
        check_field("raw_flags", want.raw_flags, verdict_if.raw_flags);
    endtask

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // word driver: one word per transfer, idles drawn per word
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_if.valid       <= 1'b0;
            pkt_if.packet_word <= '0;
            pkt_if.valid_bytes <= '0;
            pkt_if.last_word   <= 1'b0;
            gap_count = 0;
        end
        else
        begin
            // a word transfer feeds the parse model right away
            if (pkt_if.valid && pkt_if.ready)
            begin
                if (parse_word(on_wire, predicted))
                    pending_verdicts.push_back(predicted);
                words_taken++;
            end

            // offer the next word only when the slot is free; valid gets one update per edge
            if (!pkt_if.valid || pkt_if.ready)
            begin
                if (word_backlog.size() == 0 ||
                    (word_backlog[0].drain && pending_verdicts.size() != 0))
                begin
                    // nothing to send, or holding off until all verdicts are back
                    pkt_if.valid <= 1'b0;
                end
                else if (gap_count < word_backlog[0].gap)
                begin
                    gap_count++;
                    pkt_if.valid <= 1'b0;
                end
                else
                begin
                    on_wire   = word_backlog.pop_front();
                    gap_count = 0;
                    pkt_if.valid       <= 1'b1;
                    pkt_if.packet_word <= on_wire.word;
                    pkt_if.valid_bytes <= on_wire.vbytes;
                    pkt_if.last_word   <= on_wire.last;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // verdict monitor: compare each transfer, then maybe stall
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            verdict_if.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (verdict_if.valid && verdict_if.ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $error("verdict transfer with no prediction waiting, status 0x%0h",
                           verdict_if.status);
                    fault_count++;
                end
                else
                begin
                    check_verdict(pending_verdicts.pop_front());
                end
                stall_left = rx_calm ? 0 : $urandom_range(0, STALL_MAX);
            end
            // stall count runs whether or not a verdict is waiting
            if (stall_left > 0)
            begin
                stall_left--;
                verdict_if.ready <= 1'b0;
            end
            else
            begin
                verdict_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: no transfer on either channel for too long
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            if ((pkt_if.valid && pkt_if.ready) || (verdict_if.valid && verdict_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $error("no transfer for %0d cycles, %0d verdicts outstanding",
                       quiet_cycles, pending_verdicts.size());
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------

    initial
    begin
        word_xfer_t  xfer;
        int          phase;
        int unsigned budget;
        bit          first_pkt;

        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = grp_pkg::CFG_EXPECTED_PROTOCOL;
        cfg_data  = '0;
        // register defaults after reset
        settings = '{expected_protocol: grp_pkg::TEB_PROTOCOL, plain_port_present: 1'b1,
                     wide_port_present: 1'b1, min_inner_bytes: grp_pkg::INNER_ETH_BYTES};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed packets under the reset settings ----

        // lone all-ones base header, valid_bytes above four: too short, and
        // checksum/key/sequence never arrive so they read as zero
        staged.delete();
        staged.push_back('{word: 32'hFFFF_FFFF, vbytes: 3'd7, last: 1'b1, gap: 0,
                           drain: 1'b0});
        commit_packet(1'b0);

        // key plus sequence, all-ones key, zero sequence: clean wide packet
        build_packet(16'h3000, grp_pkg::TEB_PROTOCOL, 32'hFFFF_FFFF, 32'h0000_0000,
                     grp_pkg::INNER_ETH_BYTES, 1'b1);
        commit_packet(1'b0);

        // checksum packet with a payload word of zero valid bytes mid packet,
        // so the carried checksum no longer matches
        build_packet(16'h8000, grp_pkg::TEB_PROTOCOL, 32'd0, 32'd0,
                     grp_pkg::INNER_ETH_BYTES, 1'b1);
        xfer = staged[3];
        xfer.vbytes = 3'd0;
        staged[3] = xfer;
        commit_packet(1'b0);

        // routing and version bits, sequence without key
        build_packet(16'h5007, grp_pkg::TEB_PROTOCOL, 32'd0, 32'h5A5A_A5A5,
                     grp_pkg::INNER_ETH_BYTES, 1'b1);
        commit_packet(1'b0);

        // wrong protocol
        build_packet(16'h0000, 16'h0800, 32'd0, 32'd0, grp_pkg::INNER_ETH_BYTES, 1'b1);
        commit_packet(1'b0);

        // full header with good checksum but too little inner data; sender waits
        // for all earlier verdicts first
        build_packet(16'hB000, grp_pkg::TEB_PROTOCOL, $urandom, $urandom, 10, 1'b1);
        commit_packet(1'b1);

        // ---- random phases, settings changed between them ----
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                0: ;  // stay on reset settings
                1: apply_settings(16'h0000, 1'b1, 1'b0, 8'd0);
                2: apply_settings(16'hFFFF, 1'b0, 1'b1, 8'd255);
                3: apply_settings(grp_pkg::TEB_PROTOCOL, 1'b0, 1'b0, grp_pkg::INNER_ETH_BYTES);
                4: apply_settings(16'($urandom), 1'b1, 1'b1, 8'($urandom_range(0, 40)));
                default: apply_settings(16'($urandom), 1'($urandom), 1'($urandom),
                                        8'($urandom));
            endcase
            rx_calm   = ($urandom_range(0, 3) == 0);
            budget    = words_queued + RANDOM_WORDS / RANDOM_PHASES;
            first_pkt = 1'b1;
            while (words_queued < budget)
            begin
                random_packet();
                // first packet of each phase starts only after the pipe drains
                commit_packet(first_pkt);
                first_pkt = 1'b0;
            end
        end

        // ---- one longer packet with checksum and key under the reset values ----
        wait_idle();
        apply_settings(grp_pkg::TEB_PROTOCOL, 1'b1, 1'b1, grp_pkg::INNER_ETH_BYTES);
        rx_calm = 1'b0;
        build_packet(16'hA000, grp_pkg::TEB_PROTOCOL, $urandom, 32'd0,
                     LONG_WORDS * 4 - 12, 1'b1);
        commit_packet(1'b0);

        wait_idle();
        repeat (5) @(posedge clk);

        if (fault_count == 0 && pending_verdicts.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
